@@ sv/rspa_pkg.sv @@
// ----------------------------------------------------------------------------
// rspa_pkg
// shared types and constants for the rotate/scale pixel address unit
// ----------------------------------------------------------------------------
package rspa_pkg;

    // source picture geometry
    localparam int SRC_W     = 256;
    localparam int SRC_H     = 240;
    localparam int SIDE_CROP = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd3;

    // rotation codes
    localparam logic [1:0] ROT_UP  = 2'd0;
    localparam logic [1:0] ROT_CCW = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_CW  = 2'd3;

    // scale table index, wide enough for the largest picture width
    localparam int IDX_W = 9;

    // column term: offset plus column, up to 768 + 255
    localparam int COL_TERM_W = 11;

    typedef enum logic {
        FILL_ST,
        RUN_ST
    } fill_state_t;

    // scale table read request
    typedef struct packed {
        logic             col_en;
        logic             row_en;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

endpackage

@@ sv/rspa_scale_rom.sv @@
// ----------------------------------------------------------------------------
// rspa_scale_rom
// centre-sampled column and row scale tables, filled by a sweep after reset
// ----------------------------------------------------------------------------
module rspa_scale_rom
    import rspa_pkg::*;
#(
    parameter int STRETCH_WIDTH  = 292,
    parameter int STRETCH_HEIGHT = 210
) (
    input  logic         clk,
    input  logic         rst_n,
    input  rd_req_t      rd,
    output logic [7:0]   col_q,
    output logic [7:0]   row_q,
    output logic         ready
);

    localparam int COL_AW = $clog2(STRETCH_WIDTH);
    localparam int ROW_AW = $clog2(STRETCH_HEIGHT);
    localparam int REM_W  = 11;

    localparam logic [COL_AW-1:0] LAST_CNT = COL_AW'(STRETCH_WIDTH - 1);
    localparam logic [COL_AW-1:0] ROW_LIM  = COL_AW'(STRETCH_HEIGHT);
    localparam logic [REM_W-1:0]  COL_STEP = REM_W'(2 * SRC_W);
    localparam logic [REM_W-1:0]  COL_DIV  = REM_W'(2 * STRETCH_WIDTH);
    localparam logic [REM_W-1:0]  ROW_STEP = REM_W'(2 * SRC_H);
    localparam logic [REM_W-1:0]  ROW_DIV  = REM_W'(2 * STRETCH_HEIGHT);

    logic [7:0] col_mem [STRETCH_WIDTH];
    logic [7:0] row_mem [STRETCH_HEIGHT];

    fill_state_t       state_reg, state_next;
    logic              fill_en;
    logic [COL_AW-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]  col_r_reg, col_r_next;
    logic [7:0]        col_v_reg, col_v_next;
    logic [REM_W-1:0]  row_r_reg, row_r_next;
    logic [7:0]        row_v_reg, row_v_next;
    logic [REM_W-1:0]  col_sum, row_sum, row_t1;
    logic              row_inc1, row_inc2;
    logic [7:0]        col_q_reg, row_q_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FILL_ST:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = RUN_ST;
                end
            end
            RUN_ST:  state_next = RUN_ST;
            default: state_next = FILL_ST;
        endcase
    end

    // state outputs
    always_comb
    begin
        fill_en = (state_reg == FILL_ST);
        ready   = (state_reg == RUN_ST);
    end

    // incremental floor((2d+1)*src / (2*depth)) for the next entry
    always_comb
    begin
        col_sum    = col_r_reg + COL_STEP;
        col_r_next = col_sum;
        col_v_next = col_v_reg;
        if (col_sum >= COL_DIV)
        begin
            col_r_next = col_sum - COL_DIV;
            col_v_next = col_v_reg + 8'd1;
        end

        row_sum  = row_r_reg + ROW_STEP;
        row_inc1 = (row_sum >= ROW_DIV);
        row_t1   = row_inc1 ? (row_sum - ROW_DIV) : row_sum;
        row_inc2 = (row_t1 >= ROW_DIV);
        row_r_next = row_inc2 ? (row_t1 - ROW_DIV) : row_t1;
        row_v_next = row_v_reg + 8'(row_inc1) + 8'(row_inc2);

        cnt_next = cnt_reg + COL_AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_ST;
            cnt_reg   <= '0;
            col_r_reg <= REM_W'(SRC_W);
            col_v_reg <= '0;
            row_r_reg <= REM_W'(SRC_H);
            row_v_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fill_en)
            begin
                cnt_reg   <= cnt_next;
                col_r_reg <= col_r_next;
                col_v_reg <= col_v_next;
                row_r_reg <= row_r_next;
                row_v_reg <= row_v_next;
            end
        end
    end

    // column table: written by the sweep, read once running
    always_ff @(posedge clk)
    begin
        if (fill_en)
        begin
            col_mem[cnt_reg] <= col_v_reg;
        end
        if (rd.col_en)
        begin
            col_q_reg <= col_mem[rd.idx[COL_AW-1:0]];
        end
    end

    // row table
    always_ff @(posedge clk)
    begin
        if (fill_en && (cnt_reg < ROW_LIM))
        begin
            row_mem[cnt_reg[ROW_AW-1:0]] <= row_v_reg;
        end
        if (rd.row_en)
        begin
            row_q_reg <= row_mem[rd.idx[ROW_AW-1:0]];
        end
    end

    assign col_q = col_q_reg;
    assign row_q = row_q_reg;

endmodule

@@ sv/rotate_scale_pixel_address_unit.sv @@
// ----------------------------------------------------------------------------
// rotate_scale_pixel_address_unit
// maps a canvas pixel to a source row/column and framebuffer byte address
// ----------------------------------------------------------------------------
// usage
//   input: a canvas coordinate transfer happens on a clock edge with start high
//   and busy low; one coordinate may follow another on every cycle
//   output: done pulses for one cycle with is_border, source_row, source_col
//   and fetch_address; the receiver cannot stall, so every result is taken
//   result path: the input transfer loads the stage 1 registers, then the stage 2
//   and output registers; throughput: one pixel per cycle once busy is low, set
//   by the three-stage pipeline around the synchronous scale table read
//   configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   write only while no pixel is in flight
//   reset: configuration clears to upright, no mirror, no stretch, base zero;
//   the scale tables are then filled by a sweep over STRETCH_WIDTH entries with
//   busy high, after which busy stays low
//   the pipeline has no back pressure, so nothing ever stalls inside
// ----------------------------------------------------------------------------
module rotate_scale_pixel_address_unit
    import rspa_pkg::*;
#(
    parameter int CANVAS_WIDTH   = 320,
    parameter int CANVAS_HEIGHT  = 240,
    parameter int ROW_PITCH      = 256,
    parameter int ROW_OFFSET     = 0,
    parameter int STRETCH_WIDTH  = 292,
    parameter int STRETCH_HEIGHT = 210
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel command
    input  logic                 start,
    output logic                 busy,
    input  logic [9:0]           canvas_x,
    input  logic [8:0]           scanline,
    // result strobe
    output logic                 done,
    output logic                 is_border,
    output logic [7:0]           source_row,
    output logic [7:0]           source_col,
    output logic [31:0]          fetch_address,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // picture width and left edge per mode, all fixed at elaboration
    localparam int X0_UP   = (SRC_W < CANVAS_WIDTH) ? (CANVAS_WIDTH - SRC_W) / 2 : 0;
    localparam int X0_UP_S = (STRETCH_WIDTH < CANVAS_WIDTH) ?
                             (CANVAS_WIDTH - STRETCH_WIDTH) / 2 : 0;
    localparam int X0_RT   = (SRC_H < CANVAS_WIDTH) ? (CANVAS_WIDTH - SRC_H) / 2 : 0;
    localparam int X0_RT_S = (STRETCH_HEIGHT < CANVAS_WIDTH) ?
                             (CANVAS_WIDTH - STRETCH_HEIGHT) / 2 : 0;

    localparam int PITCH_W = $clog2(ROW_PITCH + 1);
    localparam int TERM_W  = 8 + PITCH_W;

    // configuration registers
    logic [1:0]  rotation_reg;
    logic        mirror_reg;
    logic        stretch_reg;
    logic [31:0] frame_base_reg;

    // stage 0: border test and table index
    logic             accept;
    logic             rom_ready;
    logic             rotated;
    logic             flip;
    logic [9:0]       pic_w;
    logic [9:0]       pic_x0;
    logic [10:0]      pic_end;
    logic             border0;
    logic [9:0]       u;
    logic [9:0]       idx0;
    rd_req_t          rd;
    logic [7:0]       col_q, row_q;

    // stage 1: after table read
    logic             s1_valid_reg;
    logic             s1_border_reg;
    logic [7:0]       s1_y_reg;
    logic [7:0]       s1_idx_reg;
    logic [7:0]       m1;
    logic [7:0]       srow1, scol1;

    // stage 2: address terms
    logic              s2_valid_reg;
    logic              s2_border_reg;
    logic [7:0]        s2_srow_reg, s2_scol_reg;
    logic [TERM_W-1:0] s2_row_term_reg, row_term_next;
    logic [COL_TERM_W-1:0] s2_col_term_reg, col_term_next;
    logic [31:0]       addr_next;

    // output registers
    logic        done_reg;
    logic        is_border_reg;
    logic [7:0]  source_row_reg, source_col_reg;
    logic [31:0] fetch_address_reg;

    assign busy      = !rom_ready;
    assign accept    = start && rom_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg   <= ROT_UP;
            mirror_reg     <= 1'b0;
            stretch_reg    <= 1'b0;
            frame_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROTATION:   rotation_reg   <= cfg_data[1:0];
                REG_MIRROR:     mirror_reg     <= cfg_data[0];
                REG_STRETCH:    stretch_reg    <= cfg_data[0];
                REG_FRAME_BASE: frame_base_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // picture window for the current mode
    always_comb
    begin
        rotated = rotation_reg[0];
        if (rotated)
        begin
            pic_w  = stretch_reg ? 10'(STRETCH_HEIGHT) : 10'(SRC_H);
            pic_x0 = stretch_reg ? 10'(X0_RT_S) : 10'(X0_RT);
        end
        else
        begin
            pic_w  = stretch_reg ? 10'(STRETCH_WIDTH) : 10'(SRC_W);
            pic_x0 = stretch_reg ? 10'(X0_UP_S) : 10'(X0_UP);
        end
        pic_end = {1'b0, pic_x0} + {1'b0, pic_w};
    end

    // border test, horizontal position inside the picture, mirror
    always_comb
    begin
        border0 = ({1'b0, scanline} >= 10'(CANVAS_HEIGHT))
               || ({1'b0, scanline} >= 10'(SRC_H))
               || ({1'b0, canvas_x} >= 11'(CANVAS_WIDTH))
               || (canvas_x < pic_x0)
               || ({1'b0, canvas_x} >= pic_end);
        flip = mirror_reg ^ (rotation_reg == ROT_180);
        u    = canvas_x - pic_x0;
        idx0 = flip ? (pic_w - 10'd1 - u) : u;

        // only stretched picture pixels touch the tables
        rd.col_en = accept && !border0 && stretch_reg && !rotated;
        rd.row_en = accept && !border0 && stretch_reg && rotated;
        rd.idx    = idx0[IDX_W-1:0];
    end

    rspa_scale_rom #(
        .STRETCH_WIDTH  (STRETCH_WIDTH),
        .STRETCH_HEIGHT (STRETCH_HEIGHT)
    ) u_scale_rom (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .col_q (col_q),
        .row_q (row_q),
        .ready (rom_ready)
    );

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_border_reg <= border0;
            s1_y_reg      <= scanline[7:0];
            s1_idx_reg    <= idx0[7:0];
        end
    end

    // source row and column per rotation
    always_comb
    begin
        if (stretch_reg)
        begin
            m1 = rotated ? row_q : col_q;
        end
        else
        begin
            m1 = s1_idx_reg;
        end

        case (rotation_reg)
            ROT_UP:
            begin
                srow1 = s1_y_reg;
                scol1 = m1;
            end
            ROT_180:
            begin
                srow1 = 8'(SRC_H - 1) - s1_y_reg;
                scol1 = m1;
            end
            ROT_CCW:
            begin
                srow1 = m1;
                scol1 = 8'(SRC_W - 1 - SIDE_CROP) - s1_y_reg;
            end
            default:
            begin
                srow1 = 8'(SRC_H - 1) - m1;
                scol1 = 8'(SIDE_CROP) + s1_y_reg;
            end
        endcase

        if (s1_border_reg)
        begin
            srow1 = '0;
            scol1 = '0;
        end

        row_term_next = TERM_W'(srow1) * TERM_W'(ROW_PITCH);
        col_term_next = COL_TERM_W'(ROW_OFFSET) + COL_TERM_W'(scol1);
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_border_reg   <= s1_border_reg;
            s2_srow_reg     <= srow1;
            s2_scol_reg     <= scol1;
            s2_row_term_reg <= row_term_next;
            s2_col_term_reg <= col_term_next;
        end
    end

    // final address, wraps at 32 bits; border gives zero
    always_comb
    begin
        addr_next = frame_base_reg + 32'(s2_row_term_reg) + 32'(s2_col_term_reg);
        if (s2_border_reg)
        begin
            addr_next = '0;
        end
    end

    // output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            is_border_reg     <= s2_border_reg;
            source_row_reg    <= s2_srow_reg;
            source_col_reg    <= s2_scol_reg;
            fetch_address_reg <= addr_next;
        end
    end

    assign done          = done_reg;
    assign is_border     = is_border_reg;
    assign source_row    = source_row_reg;
    assign source_col    = source_col_reg;
    assign fetch_address = fetch_address_reg;

    // every accepted pixel gives exactly one result, and no result comes without one
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted pixel produced no result");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without an accepted pixel");

    // no result while the tables are still being filled
    a_no_done_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result during table fill");

    // border results carry zero fields
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_border) |->
            (source_row == 8'd0 && source_col == 8'd0 && fetch_address == 32'd0))
        else $error("border result with nonzero fields");

    // picture rows stay inside the source
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_border) |-> (source_row <= 8'(SRC_H - 1)))
        else $error("source row out of range");

endmodule

@@ tb/rotate_scale_pixel_address_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rotate_scale_pixel_address_unit_tb
// self-checking bench for the canvas-to-source pixel address unit; a directed
// table covers picture edges, border cases and every rotation under several
// mirror/stretch modes, then sixteen random phases sweep all mode combinations with varying
// input gaps; every result is compared against a typed answer or a behavioral address mapper
// ----------------------------------------------------------------------------
module rotate_scale_pixel_address_unit_tb
    import rspa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // geometry used for this build, passed down to the unit
    localparam int CANVAS_WIDTH   = 320;
    localparam int CANVAS_HEIGHT  = 240;
    localparam int ROW_PITCH      = 256;
    localparam int ROW_OFFSET     = 0;
    localparam int STRETCH_WIDTH  = 292;
    localparam int STRETCH_HEIGHT = 210;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    // pipeline is three deep; a little slack before config writes and at the end
    localparam int PIPE_DRAIN   = 4;
    // cycles with no transfer of any kind before the run is declared hung;
    // covers the scale table fill after reset and the longest sender gap
    localparam int HANG_LIMIT   = 2000;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 33;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic        bord;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] addr;
    } pix_result_t;

    // one entry per issued pixel; a typed entry carries its own answer
    typedef struct packed {
        logic        typed;
        pix_result_t res;
    } pix_issue_t;

    typedef struct {
        logic [1:0]  rot;
        logic        mir;
        logic        str;
        logic [31:0] base;
        logic [9:0]  x;
        logic [8:0]  y;
        logic        typed;
        pix_result_t want;
    } dir_row_t;

    localparam pix_result_t NO_ANSWER  = '0;
    localparam pix_result_t BORDER_PIX = '{1'b1, 8'd0, 8'd0, 32'd0};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [9:0]           canvas_x = '0;
    logic [8:0]           scanline = '0;
    logic                 done;
    logic                 is_border;
    logic [7:0]           source_row;
    logic [7:0]           source_col;
    logic [31:0]          fetch_address;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // mapper copy of the configuration, updated on each config transfer
    logic [1:0]  map_rot     = ROT_UP;
    logic        map_mirror  = 1'b0;
    logic        map_stretch = 1'b0;
    logic [31:0] map_base    = '0;

    // centre-sampled scale maps
    logic [7:0] col_map [STRETCH_WIDTH];
    logic [7:0] row_map [STRETCH_HEIGHT];

    pix_issue_t  issue_q[$];
    pix_result_t addr_expect_q[$];
    int          fail_count  = 0;
    int          hang_cycles = 0;

    // picture edges: upright x0 = 32, upright stretched x0 = 14,
    // rotated x0 = 40, rotated stretched x0 = 55
    dir_row_t dir_tab [DIR_ROWS] = '{
        // reset config: first and last picture pixel, both sides of the border
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd32,   9'd0,   1'b1, '{1'b0, 8'd0, 8'd0, 32'd0}},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd287,  9'd239, 1'b1,
            '{1'b0, 8'd239, 8'd255, 32'd61439}},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd31,   9'd0,   1'b1, BORDER_PIX},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd288,  9'd0,   1'b1, BORDER_PIX},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd1023, 9'd511, 1'b1, BORDER_PIX},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd100,  9'd240, 1'b1, BORDER_PIX},
        '{ROT_UP,  1'b0, 1'b0, 32'h0,         10'd0,    9'd0,   1'b1, BORDER_PIX},
        // address wraps past 2^32
        '{ROT_UP,  1'b0, 1'b0, 32'hFFFF_FFFF, 10'd287,  9'd239, 1'b1,
            '{1'b0, 8'd239, 8'd255, 32'h0000_EFFE}},
        '{ROT_UP,  1'b1, 1'b0, 32'h1234_5678, 10'd32,   9'd5,   1'b0, NO_ANSWER},
        '{ROT_UP,  1'b0, 1'b1, 32'h0,         10'd14,   9'd0,   1'b0, NO_ANSWER},
        '{ROT_UP,  1'b0, 1'b1, 32'h0,         10'd305,  9'd239, 1'b0, NO_ANSWER},
        '{ROT_UP,  1'b0, 1'b1, 32'h0,         10'd306,  9'd10,  1'b1, BORDER_PIX},
        // quarter turns crop eight columns each side
        '{ROT_CCW, 1'b0, 1'b0, 32'h0,         10'd40,   9'd0,   1'b0, NO_ANSWER},
        '{ROT_CCW, 1'b0, 1'b0, 32'h0,         10'd279,  9'd239, 1'b0, NO_ANSWER},
        '{ROT_CCW, 1'b0, 1'b0, 32'h0,         10'd39,   9'd0,   1'b1, BORDER_PIX},
        '{ROT_CCW, 1'b0, 1'b0, 32'h0,         10'd320,  9'd5,   1'b1, BORDER_PIX},
        '{ROT_CCW, 1'b1, 1'b1, 32'h0,         10'd55,   9'd100, 1'b0, NO_ANSWER},
        '{ROT_CCW, 1'b0, 1'b1, 32'h0,         10'd264,  9'd0,   1'b0, NO_ANSWER},
        // half turn flips both axes, mirror undoes the horizontal flip
        '{ROT_180, 1'b0, 1'b0, 32'h0,         10'd32,   9'd0,   1'b0, NO_ANSWER},
        '{ROT_180, 1'b1, 1'b0, 32'h0,         10'd287,  9'd239, 1'b0, NO_ANSWER},
        '{ROT_180, 1'b0, 1'b1, 32'h0,         10'd160,  9'd120, 1'b0, NO_ANSWER},
        '{ROT_CW,  1'b0, 1'b0, 32'h0,         10'd40,   9'd0,   1'b0, NO_ANSWER},
        '{ROT_CW,  1'b1, 1'b1, 32'h0,         10'd264,  9'd239, 1'b0, NO_ANSWER},
        '{ROT_CW,  1'b0, 1'b1, 32'h0,         10'd54,   9'd50,  1'b1, BORDER_PIX},
        '{ROT_CW,  1'b1, 1'b0, 32'h0,         10'd319,  9'd0,   1'b1, BORDER_PIX}
    };

    rotate_scale_pixel_address_unit #(
        .CANVAS_WIDTH   (CANVAS_WIDTH),
        .CANVAS_HEIGHT  (CANVAS_HEIGHT),
        .ROW_PITCH      (ROW_PITCH),
        .ROW_OFFSET     (ROW_OFFSET),
        .STRETCH_WIDTH  (STRETCH_WIDTH),
        .STRETCH_HEIGHT (STRETCH_HEIGHT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .canvas_x      (canvas_x),
        .scanline      (scanline),
        .done          (done),
        .is_border     (is_border),
        .source_row    (source_row),
        .source_col    (source_col),
        .fetch_address (fetch_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // canvas coordinate to source row/column/address under the current mode
    function automatic pix_result_t map_pixel(input logic [9:0] x, input logic [8:0] y);
        int unsigned xi;
        int unsigned yi;
        int unsigned w;
        int unsigned x0;
        int unsigned u;
        int unsigned idx;
        int unsigned m;
        int unsigned srow;
        int unsigned scol;
        bit          turned;
        bit          flip;
        pix_result_t r;
        r = '0;
        xi = 32'(x);
        yi = 32'(y);
        turned = map_rot[0];
        if (turned)
            w = map_stretch ? STRETCH_HEIGHT : SRC_H;
        else
            w = map_stretch ? STRETCH_WIDTH : SRC_W;
        // picture centred on the canvas, pinned to the left edge if too wide
        x0 = (w < CANVAS_WIDTH) ? (CANVAS_WIDTH - w) / 2 : 0;
        if (yi >= CANVAS_HEIGHT || yi >= SRC_H || xi >= CANVAS_WIDTH || xi < x0 ||
            xi >= x0 + w)
        begin
            r.bord = 1'b1;
            return r;
        end
        u = xi - x0;
        // half turn mirrors on its own, the mirror bit toggles that
        flip = map_mirror ^ (map_rot == ROT_180);
        idx = flip ? (w - 1 - u) : u;
        if (map_stretch)
            m = turned ? 32'(row_map[idx]) : 32'(col_map[idx]);
        else
            m = idx;
        case (map_rot)
            ROT_UP:
            begin
                srow = yi;
                scol = m;
            end
            ROT_180:
            begin
                srow = SRC_H - 1 - yi;
                scol = m;
            end
            ROT_CCW:
            begin
                srow = m;
                scol = SRC_W - 1 - SIDE_CROP - yi;
            end
            default:
            begin
                srow = SRC_H - 1 - m;
                scol = SIDE_CROP + yi;
            end
        endcase
        r.row  = srow[7:0];
        r.col  = scol[7:0];
        // 32-bit unsigned math wraps like the framebuffer address
        r.addr = map_base + srow * ROW_PITCH + ROW_OFFSET + scol;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: one process sees every transfer at the clock edge, so the
    // mapper state, the expectations and the hang counter stay in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_issue_t  issue;
        pix_result_t want;
        if (rst_n)
        begin
            hang_cycles++;
            // config transfer updates the mapper copy of the registers
            if (cfg_valid && cfg_ready)
            begin
                hang_cycles = 0;
                case (cfg_index)
                    REG_ROTATION:   map_rot     = cfg_data[1:0];
                    REG_MIRROR:     map_mirror  = cfg_data[0];
                    REG_STRETCH:    map_stretch = cfg_data[0];
                    REG_FRAME_BASE: map_base    = cfg_data;
                    default: ;
                endcase
            end
            // coordinate transfer: take the typed answer or map it here
            if (start && !busy)
            begin
                hang_cycles = 0;
                issue = issue_q.pop_front();
                if (issue.typed)
                    addr_expect_q.push_back(issue.res);
                else
                    addr_expect_q.push_back(map_pixel(canvas_x, scanline));
            end
            // result strobe is taken on this edge, no hold-off possible
            if (done)
            begin
                hang_cycles = 0;
                if (addr_expect_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none actual %0h/%0h/%0h/%0h",
                             $realtime, is_border, source_row, source_col, fetch_address);
                end
                else
                begin
                    want = addr_expect_q.pop_front();
                    check_field("is_border", 32'(want.bord), 32'(is_border));
                    check_field("source_row", 32'(want.row), 32'(source_row));
                    check_field("source_col", 32'(want.col), 32'(source_col));
                    check_field("fetch_address", want.addr, fetch_address);
                end
            end
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, HANG_LIMIT);
                $display("** rotate_scale_pixel_address_unit: FAILED **");
                $finish;
            end
        end
    end

    // issue one coordinate; each cycle stays idle with the given odds
    task automatic send_pixel(input logic [9:0] x, input logic [8:0] y, input logic typed,
                              input pix_result_t res, input int idle_pct);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        issue_q.push_back('{typed, res});
        start    <= 1'b1;
        canvas_x <= x;
        scanline <= y;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // register write, only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (addr_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // narrow registers get random upper bits, which the unit must drop
    task automatic write_mode(input logic [1:0] rot, input logic mir, input logic str,
                              input logic [31:0] base);
        write_reg(REG_ROTATION, ($urandom() & 32'hFFFF_FFFC) | 32'(rot));
        write_reg(REG_MIRROR, ($urandom() & 32'hFFFF_FFFE) | 32'(mir));
        write_reg(REG_STRETCH, ($urandom() & 32'hFFFF_FFFE) | 32'(str));
        write_reg(REG_FRAME_BASE, base);
    endtask

    initial
    begin
        logic [1:0]  cur_rot;
        logic        cur_mir;
        logic        cur_str;
        logic [31:0] cur_base;
        logic [31:0] base;
        logic [9:0]  x;
        logic [8:0]  y;
        int          idle_pct;
        // scale maps sample each output pixel at its centre
        for (int d = 0; d < STRETCH_WIDTH; d++)
            col_map[d] = 8'(((2 * d + 1) * SRC_W) / (2 * STRETCH_WIDTH));
        for (int d = 0; d < STRETCH_HEIGHT; d++)
            row_map[d] = 8'(((2 * d + 1) * SRC_H) / (2 * STRETCH_HEIGHT));
        cur_rot  = ROT_UP;
        cur_mir  = 1'b0;
        cur_str  = 1'b0;
        cur_base = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, back to back within a mode; the unit holds busy
        // through the table fill, so the first transfer waits on that
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].rot != cur_rot || dir_tab[i].mir != cur_mir ||
                dir_tab[i].str != cur_str || dir_tab[i].base != cur_base)
            begin
                cur_rot  = dir_tab[i].rot;
                cur_mir  = dir_tab[i].mir;
                cur_str  = dir_tab[i].str;
                cur_base = dir_tab[i].base;
                write_mode(cur_rot, cur_mir, cur_str, cur_base);
            end
            send_pixel(dir_tab[i].x, dir_tab[i].y, dir_tab[i].typed, dir_tab[i].want, 0);
        end

        // random phases: every rotation/mirror/stretch combination once,
        // cycling through no gaps, frequent gaps and rare gaps
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                base = '0;
            else if (ph == 1 || ph == RAND_PHASES - 1)
                base = 32'hFFFF_FFFF - $urandom_range(0, 255);
            else
                base = $urandom();
            write_mode(ph[1:0], ph[2], ph[3], base);
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 68;
                default: idle_pct = 9;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly coordinates on the canvas, some anywhere in range
                if ($urandom_range(9) < 8)
                begin
                    x = 10'($urandom_range(0, CANVAS_WIDTH - 1));
                    y = 9'($urandom_range(0, SRC_H - 1));
                end
                else
                begin
                    x = 10'($urandom_range(0, 1023));
                    y = 9'($urandom_range(0, 511));
                end
                send_pixel(x, y, 1'b0, NO_ANSWER, idle_pct);
            end
        end

        // drain and let any stray strobe show up
        start <= 1'b0;
        @(posedge clk);
        while (addr_expect_q.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("** rotate_scale_pixel_address_unit: PASSED **");
        else
            $display("** rotate_scale_pixel_address_unit: FAILED **");
        $finish;
    end

endmodule
